// ===== hw/rtl/tun_pkg.sv =====
// shared types and widths for the triangle unit normal pipeline
// no dependencies
package tun_pkg;

    localparam int COORD_WIDTH      = 24;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_WIDTH     = NORMAL_FRAC_BITS + 2;
    localparam int EDGE_W           = COORD_WIDTH + 1;
    localparam int PROD_W           = 2 * EDGE_W;
    localparam int MAG_W            = PROD_W;
    localparam int HALF_W           = (MAG_W + 1) / 2;
    localparam int PP_W             = 2 * HALF_W;
    localparam int SQ_W             = 2 * MAG_W;
    localparam int LEN_W            = SQ_W + 2;
    localparam int Q_W              = NORMAL_FRAC_BITS + 1;
    localparam int QL_W             = LEN_W + Q_W;
    localparam int TGT_W            = SQ_W + 2 * NORMAL_FRAC_BITS;
    localparam int TRY_W            = QL_W + Q_W + 2;
    localparam int BIT_W            = $clog2(Q_W);
    localparam int SHIFT_W          = $clog2(2 * Q_W);
    localparam int FRONT_STAGES     = 6;
    localparam int NUM_STAGES       = FRONT_STAGES + Q_W + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]      edge_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t bx;
        coord_t by_coord;
        coord_t bz;
        coord_t cx;
        coord_t cy;
        coord_t cz;
    } tri_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } cross_t;

    typedef struct packed {
        logic [SQ_W-1:0]  sq;
        logic [TGT_W-1:0] p;
        logic [QL_W-1:0]  ql;
        logic [Q_W-1:0]   q;
        logic             neg;
    } lane_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             degen;
        lane_t [2:0]      lane;
    } search_t;

endpackage

// ===== hw/rtl/tun_cross.sv =====
// edge vectors, products and cross product, three register stages
// depends on tun_pkg
module tun_cross (
    input  logic          aclk,
    input  logic [2:0]    en,
    input  tun_pkg::tri_t tri_in,
    output tun_pkg::cross_t cross_reg
);
    import tun_pkg::*;

    edge_t e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    logic signed [PROD_W-1:0] p_reg [6];
    logic signed [PROD_W:0]   n [3];
    cross_t cross_next;

    function automatic edge_t sub_ext(coord_t a, coord_t b);
        return edge_t'({a[COORD_WIDTH-1], a}) - edge_t'({b[COORD_WIDTH-1], b});
    endfunction

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            e1x_reg <= sub_ext(tri_in.bx, tri_in.ax);
            e1y_reg <= sub_ext(tri_in.by_coord, tri_in.ay);
            e1z_reg <= sub_ext(tri_in.bz, tri_in.az);
            e2x_reg <= sub_ext(tri_in.cx, tri_in.ax);
            e2y_reg <= sub_ext(tri_in.cy, tri_in.ay);
            e2z_reg <= sub_ext(tri_in.cz, tri_in.az);
        end
        if (en[1]) begin
            p_reg[0] <= e1y_reg * e2z_reg;
            p_reg[1] <= e1z_reg * e2y_reg;
            p_reg[2] <= e1z_reg * e2x_reg;
            p_reg[3] <= e1x_reg * e2z_reg;
            p_reg[4] <= e1x_reg * e2y_reg;
            p_reg[5] <= e1y_reg * e2x_reg;
        end
        if (en[2]) begin
            cross_reg <= cross_next;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n[i] = {p_reg[2*i][PROD_W-1], p_reg[2*i]} - {p_reg[2*i+1][PROD_W-1], p_reg[2*i+1]};
            cross_next.neg[i] = n[i][PROD_W];
            cross_next.mag[i] = n[i][PROD_W] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
        end
    end

endmodule

// ===== hw/rtl/tun_square.sv =====
// squares of the cross components and squared length, three register stages
// depends on tun_pkg
module tun_square (
    input  logic             aclk,
    input  logic [2:0]       en,
    input  tun_pkg::cross_t  cross_in,
    output tun_pkg::search_t srch_reg
);
    import tun_pkg::*;

    logic [PP_W-1:0] hh_reg [3];
    logic [PP_W-1:0] hl_reg [3];
    logic [PP_W-1:0] ll_reg [3];
    logic [2:0]      neg1_reg, neg2_reg;
    logic [SQ_W-1:0] sq_reg [3];
    logic [HALF_W-1:0] h [3];
    logic [HALF_W-1:0] l [3];
    search_t srch_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            h[i] = HALF_W'(cross_in.mag[i] >> HALF_W);
            l[i] = cross_in.mag[i][HALF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= h[i] * h[i];
                hl_reg[i] <= h[i] * l[i];
                ll_reg[i] <= l[i] * l[i];
            end
            neg1_reg <= cross_in.neg;
        end
        if (en[1]) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2 * HALF_W))
                           + (SQ_W'(hl_reg[i]) << (HALF_W + 1))
                           + SQ_W'(ll_reg[i]);
            end
            neg2_reg <= neg1_reg;
        end
        if (en[2]) begin
            srch_reg <= srch_next;
        end
    end

    always_comb begin
        srch_next.len = LEN_W'(sq_reg[0]) + LEN_W'(sq_reg[1]) + LEN_W'(sq_reg[2]);
        srch_next.degen = (srch_next.len == '0);
        for (int i = 0; i < 3; i++) begin
            srch_next.lane[i].sq  = sq_reg[i];
            srch_next.lane[i].p   = '0;
            srch_next.lane[i].ql  = '0;
            srch_next.lane[i].q   = '0;
            srch_next.lane[i].neg = neg2_reg[i];
        end
    end

endmodule

// ===== hw/rtl/tun_search_stage.sv =====
// one quotient bit of the normalized components: q^2*len <= c^2*2^(2f)
// depends on tun_pkg
module tun_search_stage (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [tun_pkg::BIT_W-1:0] bit_idx,
    input  tun_pkg::search_t         srch_in,
    output tun_pkg::search_t         srch_reg
);
    import tun_pkg::*;

    logic [SHIFT_W-1:0] sh1, sh2;
    logic [TRY_W-1:0]   trial [3];
    logic [TRY_W-1:0]   tgt [3];
    search_t srch_next;

    always_comb begin
        sh1 = SHIFT_W'(bit_idx) + SHIFT_W'(1);
        sh2 = SHIFT_W'(bit_idx) << 1;
        srch_next = srch_in;
        for (int i = 0; i < 3; i++) begin
            tgt[i]   = TRY_W'(srch_in.lane[i].sq) << (2 * NORMAL_FRAC_BITS);
            trial[i] = TRY_W'(srch_in.lane[i].p)
                     + (TRY_W'(srch_in.lane[i].ql) << sh1)
                     + (TRY_W'(srch_in.len) << sh2);
            if (trial[i] <= tgt[i]) begin
                srch_next.lane[i].p  = TGT_W'(trial[i]);
                srch_next.lane[i].ql = srch_in.lane[i].ql + (QL_W'(srch_in.len) << bit_idx);
                srch_next.lane[i].q  = srch_in.lane[i].q | (Q_W'(1) << bit_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            srch_reg <= srch_next;
        end
    end

endmodule

// ===== hw/rtl/triangle_unit_normal_top.sv =====
// triangle unit normal: cross product, squared length, bitwise quotient search
// depends on tun_pkg, tun_cross, tun_square, tun_search_stage
//
// channel  dir  tdata                          tuser
// s_       in   ax..cz, 9 x 24 bit, ax lowest   -
// m_       out  normal_x, normal_y, normal_z    degenerate
//
// 22 register stages, one triangle per cycle while m_tready does not stall the output
// the 15 quotient-bit stages of the normalize step set the depth
// aresetn clears the valid bits only
// a stall fills bubbles first; s_tready drops only when every stage ahead is full
module triangle_unit_normal_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [215:0] s_tdata,   // ax, ay, az, bx, by_coord, bz, cx, cy, cz
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // normal_x, normal_y, normal_z
    output logic         m_tuser    // degenerate
);
    import tun_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg, vld_next, en;
    tri_t    tri_in;
    cross_t  cross_q;
    search_t srch [Q_W+1];
    lane_t   lane_last [3];
    logic [NORMAL_WIDTH-1:0] norm [3];
    logic [NORMAL_WIDTH-1:0] nx_reg, ny_reg, nz_reg;
    logic degen_reg;

    assign tri_in.ax       = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.ay       = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.az       = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.bx       = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.by_coord = s_tdata[4*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.bz       = s_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.cx       = s_tdata[6*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.cy       = s_tdata[7*COORD_WIDTH +: COORD_WIDTH];
    assign tri_in.cz       = s_tdata[8*COORD_WIDTH +: COORD_WIDTH];

    always_comb begin
        en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = en[0];

    tun_cross u_cross (
        .aclk      (aclk),
        .en        (en[2:0]),
        .tri_in    (tri_in),
        .cross_reg (cross_q)
    );

    tun_square u_square (
        .aclk     (aclk),
        .en       (en[5:3]),
        .cross_in (cross_q),
        .srch_reg (srch[0])
    );

    for (genvar g = 0; g < Q_W; g++) begin : g_search
        tun_search_stage u_stage (
            .aclk     (aclk),
            .en       (en[FRONT_STAGES + g]),
            .bit_idx  (BIT_W'(Q_W - 1 - g)),
            .srch_in  (srch[g]),
            .srch_reg (srch[g+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lane_last[i] = srch[Q_W].lane[i];
            if (srch[Q_W].degen) begin
                norm[i] = '0;
            end else if (lane_last[i].neg) begin
                norm[i] = -{1'b0, lane_last[i].q};
            end else begin
                norm[i] = {1'b0, lane_last[i].q};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NUM_STAGES-1]) begin
            nx_reg    <= norm[0];
            ny_reg    <= norm[1];
            nz_reg    <= norm[2];
            degen_reg <= srch[Q_W].degen;
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {nz_reg, ny_reg, nx_reg};
    assign m_tuser  = degen_reg;

`ifndef SYNTHESIS
    a_degen_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate beat with nonzero normal");

    a_norm_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(nx_reg) <= 16384 && $signed(nx_reg) >= -16384
                   && $signed(ny_reg) <= 16384 && $signed(ny_reg) >= -16384
                   && $signed(nz_reg) <= 16384 && $signed(nz_reg) >= -16384))
        else $error("normal component out of unit range");

    a_ready_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NUM_STAGES-1] |-> s_tready)
        else $error("input stalled with empty output stage");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (vld_reg[NUM_STAGES-1] && $stable(m_tdata)))
        else $error("stalled output beat lost");
`endif

endmodule
